// ===== rtl/core/bh_pkg.sv =====
// Shared types and constants for the byte histogram block.
`timescale 1ns / 1ps

package bh_pkg;

	localparam int BINS       = 256;
	localparam int IDX_WIDTH  = 8;
	localparam int OUT_WIDTH  = 32;

	// Item operation codes.
	localparam logic CMD_COUNT = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef struct packed {
		logic                 cmd;
		logic [IDX_WIDTH-1:0] symbol;
		logic                 first_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [IDX_WIDTH-1:0] bin_index;
		logic [OUT_WIDTH-1:0] bin_count;
		logic                 saturated;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;    // take the item in and issue the bin read
		logic clear_all;  // invalidate every bin
		logic update;     // read data is back: form the result
		logic incr;       // add one to the bin and write it back
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic at_max;     // the addressed bin holds its maximum count
	} dp_status_t;

endpackage

// ===== rtl/core/bh_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module bh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/bh_ctrl.sv =====
// Controller state machine for the byte histogram.
`timescale 1ns / 1ps

module bh_ctrl
	import bh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  in_item_t   item,
	input  dp_status_t status,
	output logic       busy,
	output dp_cmd_t    cmd
);

	localparam logic [0:0] ST_IDLE   = 1'b0;
	localparam logic [0:0] ST_UPDATE = 1'b1;

	logic [0:0] state_q;
	logic [0:0] state_d;
	logic       count_op_q;
	logic       accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_op_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_op_q <= (item.cmd == CMD_COUNT);
			end
		end
	end

	// The flag only clears the bins on a count item.
	always_comb begin
		cmd.capture   = accept;
		cmd.clear_all = accept && (item.cmd == CMD_COUNT) && item.first_of_stream;
		cmd.update    = (state_q == ST_UPDATE);
		cmd.incr      = (state_q == ST_UPDATE) && count_op_q && !status.at_max;
	end

endmodule

// ===== rtl/core/bh_datapath.sv =====
// Datapath of the byte histogram: bin memory, valid bits, counter update, result register.
`timescale 1ns / 1ps

module bh_datapath
	import bh_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   item,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output logic       done,
	output out_item_t  result
);

	logic [BINS-1:0]        valid_q;
	logic [IDX_WIDTH-1:0]   idx_q;
	logic [COUNT_WIDTH-1:0] rdata;
	logic [COUNT_WIDTH-1:0] old_cnt;
	logic [COUNT_WIDTH-1:0] new_cnt;
	logic [OUT_WIDTH-1:0]   cnt_out;
	logic                   done_q;
	out_item_t              result_q;

	bh_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(BINS)
	) u_bins (
		.clk  (clk),
		.we   (cmd.incr),
		.waddr(idx_q),
		.wdata(new_cnt),
		.raddr(item.symbol),
		.rdata(rdata)
	);

	// A bin never written since the last clear reads as zero.
	assign old_cnt       = valid_q[idx_q] ? rdata : '0;
	assign status.at_max = (old_cnt == {COUNT_WIDTH{1'b1}});
	assign new_cnt       = cmd.incr ? (old_cnt + 1'b1) : old_cnt;

	generate
		if (COUNT_WIDTH >= OUT_WIDTH) begin : g_trunc
			assign cnt_out = new_cnt[OUT_WIDTH-1:0];
		end else begin : g_ext
			assign cnt_out = {{(OUT_WIDTH-COUNT_WIDTH){1'b0}}, new_cnt};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.update;
			if (cmd.clear_all) begin
				valid_q <= '0;
			end else if (cmd.incr) begin
				valid_q[idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q <= item.symbol;
		end
		if (cmd.update) begin
			result_q.bin_index <= idx_q;
			result_q.bin_count <= cnt_out;
			result_q.saturated <= (new_cnt == {COUNT_WIDTH{1'b1}});
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/core/byte_histogram.sv =====
// Top level of the byte histogram: 256 saturating bin counters.
//
// Usage: an item is accepted at a rising edge where start is high and busy is
// low. A count item (cmd = count) adds one to the bin of its symbol; when its
// first_of_stream flag is set, every bin is cleared before the byte is
// counted. A read item returns the named bin's count and changes nothing.
// Every item gives exactly one result on the result port, marked by done for
// a single cycle; the receiver cannot stall, so it must take it then.
// Timing: the bin memory is read at the accept edge, the counter is updated
// and written back in the next cycle, and done rises in the cycle after that.
// Because of the read-modify-write through the single bin memory, a new item
// is not accepted while the previous one is in its update; busy is high
// during the update cycle, and a new item may be accepted in the very cycle
// that done is shown.
// Counters stop at all ones and report saturated while they sit there.
// Reset clears all bin valid bits at once, so no clearing pass is needed and
// the block is ready as soon as reset is released; the same valid bits let the
// first-of-stream clear take effect at the accept edge with no clearing pass.
`timescale 1ns / 1ps

module byte_histogram
	import bh_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_item_t  item,
	output logic      busy,
	output logic      done,
	output out_item_t result
);

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	bh_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.item  (item),
		.status(dp_status),
		.busy  (busy),
		.cmd   (dp_cmd)
	);

	bh_datapath #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (dp_cmd),
		.status(dp_status),
		.done  (done),
		.result(result)
	);

	// Every accepted item is followed by its result on done after the update cycle.
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result missing two cycles after accept");

	// The result cycle always finds the block ready for the next item.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while a result is shown");

	// The controller stays busy for one cycle only.
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	// A result is only produced after an item was taken.
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding update cycle");

endmodule
